/* hw/rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes of the stable priority event queue
// Request and result item layouts, slot entry layout, opcodes, status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TAKE   = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_TAKEN    = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  typedef struct packed {
    logic               op;
    logic        [15:0] event_tag;
    logic signed [15:0] priority_req;
    logic        [15:0] receiver;
    logic        [15:0] event_type;
    logic               match_any_type;
    logic               keep_slots;
    logic        [5:0]  insertion_offset;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic        [15:0] out_tag;
    logic signed [15:0] out_priority;
    logic        [15:0] out_type;
    logic               last;
  } out_item_t;

  // kind: 1 live, 0 tombstone
  typedef struct packed {
    logic        [15:0] tag;
    logic signed [15:0] prio;
    logic        [15:0] rcv;
    logic        [15:0] typ;
    logic               kind;
  } slot_entry_t;

  typedef struct packed {
    logic live;
    logic ge;
    logic hit;
  } cmp_res_t;

endpackage

/* hw/rtl/spq_cmp.sv */
// ----------------------------------------------------------------------------
// spq_cmp: slot compare unit
// Compares one slot entry against the current request: priority order for
// inserts, receiver and type match for takes.
// ----------------------------------------------------------------------------
module spq_cmp import spq_pkg::*; (
  input  slot_entry_t entry,
  input  in_item_t    req,
  output cmp_res_t    res
);

  always_comb begin
    res.live = entry.kind;
    res.ge   = (entry.prio >= req.priority_req);
    res.hit  = entry.kind && (entry.rcv == req.receiver) &&
               (req.match_any_type || (entry.typ == req.event_type));
  end

endmodule

/* hw/rtl/stable_priority_event_queue_unit.sv */
// ----------------------------------------------------------------------------
// stable_priority_event_queue_unit: ordered slot table of posted events
// Inserts rank by descending priority from the offset on, stable among equals;
// takes pull matching live entries in order, compacting or leaving tombstones.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  in_item_t  (op, tag, priority, ...)
//  out      output     out_valid/out_stall  out_item_t (status, tag, ..., last)
//
//  one item at a time; the slot memory (one read, one write per cycle)
//  sets the pace: takes read every used slot, inserts may scan and shift
//  each take result also waits for the output register to be free
//  reset empties the table at once (used count to zero), no clearing pass
//  a held result does not block the next request from being accepted
// ----------------------------------------------------------------------------
module stable_priority_event_queue_unit import spq_pkg::*; #(
  parameter int SLOTS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int XW = (CW > 6) ? CW : 6;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RESP    = 3'd1;
  localparam logic [2:0] S_I_LAST  = 3'd2;
  localparam logic [2:0] S_I_SCAN  = 3'd3;
  localparam logic [2:0] S_I_SHIFT = 3'd4;
  localparam logic [2:0] S_I_PUT   = 3'd5;
  localparam logic [2:0] S_T_EVAL  = 3'd6;
  localparam logic [2:0] S_T_END   = 3'd7;

  logic [2:0]    state_r, state_nxt;
  in_item_t      req_r, req_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] wr_r, wr_nxt;
  logic [1:0]    resp_st_r, resp_st_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  out_item_t     pend_r, pend_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  logic          out_load;
  out_item_t     out_load_data;
  logic          out_free;
  logic          accept;

  slot_entry_t   slot_mem [SLOTS];
  slot_entry_t   mem_rdata_r;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_raddr, mem_waddr;
  slot_entry_t   mem_wdata;

  cmp_res_t      cmp;
  logic [XW-1:0] off_x, used_x;
  logic [CW-1:0] idx_inc, wr_dec;
  slot_entry_t   new_entry;
  slot_entry_t   tomb_entry;

  function automatic logic [AW-1:0] wr_addr(input logic [CW-1:0] cnt);
    return cnt[AW-1:0];
  endfunction

  spq_cmp u_cmp (
    .entry (mem_rdata_r),
    .req   (req_r),
    .res   (cmp)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign off_x   = XW'(in_data.insertion_offset);
  assign used_x  = XW'(used_r);
  assign idx_inc = idx_r + CW'(1);
  assign wr_dec  = wr_r - CW'(1);

  always_comb begin
    new_entry.tag  = req_r.event_tag;
    new_entry.prio = req_r.priority_req;
    new_entry.rcv  = req_r.receiver;
    new_entry.typ  = req_r.event_type;
    new_entry.kind = 1'b1;
    tomb_entry      = mem_rdata_r;
    tomb_entry.kind = 1'b0;
  end

  // slot memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= slot_mem[mem_raddr];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    used_nxt       = used_r;
    idx_nxt        = idx_r;
    wr_nxt         = wr_r;
    resp_st_nxt    = resp_st_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_load       = 1'b0;
    out_load_data  = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = mem_rdata_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt = in_data;
          if (in_data.op == OP_TAKE) begin
            idx_nxt        = '0;
            wr_nxt         = '0;
            pend_valid_nxt = 1'b0;
            if (used_r == '0) begin
              state_nxt = S_T_END;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              state_nxt = S_T_EVAL;
            end
          end else if (used_r == CW'(SLOTS)) begin
            resp_st_nxt = ST_FULL;
            state_nxt   = S_RESP;
          end else if (used_r == '0 || off_x >= used_x) begin
            idx_nxt   = used_r;
            state_nxt = S_I_PUT;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = wr_addr(used_r - CW'(1));
            state_nxt = S_I_LAST;
          end
        end
      end
      S_I_LAST: begin
        if (cmp.live && cmp.ge) begin
          idx_nxt   = used_r;
          state_nxt = S_I_PUT;
        end else begin
          idx_nxt   = CW'(req_r.insertion_offset);
          mem_re    = 1'b1;
          mem_raddr = wr_addr(CW'(req_r.insertion_offset));
          state_nxt = S_I_SCAN;
        end
      end
      S_I_SCAN: begin
        if (!cmp.live || cmp.ge) begin
          idx_nxt = idx_inc;
          if (idx_inc < used_r) begin
            mem_re    = 1'b1;
            mem_raddr = wr_addr(idx_inc);
          end else begin
            state_nxt = S_I_PUT;
          end
        end else begin
          // open a gap at idx by moving the tail up one slot
          wr_nxt    = used_r;
          mem_re    = 1'b1;
          mem_raddr = wr_addr(used_r - CW'(1));
          state_nxt = S_I_SHIFT;
        end
      end
      S_I_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = wr_addr(wr_r);
        mem_wdata = mem_rdata_r;
        wr_nxt    = wr_dec;
        if (wr_dec > idx_r) begin
          mem_re    = 1'b1;
          mem_raddr = wr_addr(wr_dec - CW'(1));
        end else begin
          state_nxt = S_I_PUT;
        end
      end
      S_I_PUT: begin
        mem_we      = 1'b1;
        mem_waddr   = wr_addr(idx_r);
        mem_wdata   = new_entry;
        used_nxt    = used_r + CW'(1);
        resp_st_nxt = ST_INSERTED;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          out_load             = 1'b1;
          out_load_data.status = resp_st_r;
          out_load_data.last   = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      S_T_EVAL: begin
        // a hit holds back one result so the final one can carry last
        if (!cmp.hit || !pend_valid_r || out_free) begin
          if (cmp.hit) begin
            if (pend_valid_r) begin
              out_load      = 1'b1;
              out_load_data = pend_r;
            end
            pend_valid_nxt        = 1'b1;
            pend_nxt.status       = ST_TAKEN;
            pend_nxt.out_tag      = mem_rdata_r.tag;
            pend_nxt.out_priority = mem_rdata_r.prio;
            pend_nxt.out_type     = mem_rdata_r.typ;
            pend_nxt.last         = 1'b0;
            if (req_r.keep_slots) begin
              mem_we    = 1'b1;
              mem_waddr = wr_addr(wr_r);
              mem_wdata = tomb_entry;
              wr_nxt    = wr_r + CW'(1);
            end
          end else begin
            mem_we    = 1'b1;
            mem_waddr = wr_addr(wr_r);
            mem_wdata = mem_rdata_r;
            wr_nxt    = wr_r + CW'(1);
          end
          idx_nxt = idx_inc;
          if (idx_inc < used_r) begin
            mem_re    = 1'b1;
            mem_raddr = wr_addr(idx_inc);
          end else begin
            state_nxt = S_T_END;
          end
        end
      end
      S_T_END: begin
        if (out_free) begin
          out_load = 1'b1;
          if (pend_valid_r) begin
            out_load_data      = pend_r;
            out_load_data.last = 1'b1;
          end else begin
            out_load_data.status = ST_NONE;
            out_load_data.last   = 1'b1;
          end
          used_nxt       = wr_r;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_load || (out_valid_r && out_stall);
    out_data_nxt  = out_load ? out_load_data : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_r       <= '0;
      idx_r        <= '0;
      wr_r         <= '0;
      resp_st_r    <= ST_INSERTED;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      idx_r        <= idx_nxt;
      wr_r         <= wr_nxt;
      resp_st_r    <= resp_st_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(SLOTS))
    else $error("used count beyond table size");

  a_pend_in_take: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (state_r == S_T_EVAL || state_r == S_T_END))
    else $error("held take result outside a take");

  a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_T_EVAL) |-> (wr_r <= idx_r))
    else $error("compaction write pointer ahead of read pointer");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_I_SHIFT) |-> (wr_r > idx_r && wr_r <= used_r))
    else $error("tail shift outside its range");

endmodule

/* tb/sv/spq_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spq_result_checker: predictor and scoreboard for the event queue
// Keeps a mirror of the slot table, works out the results that each accepted
// request should produce and compares every accepted result, field by field,
// against the oldest result still owed.
// ----------------------------------------------------------------------------
module spq_result_checker import spq_pkg::*; #(
  parameter int SLOTS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        mismatch_count,
  output int        results_owed
);

  slot_entry_t slots_mirror [SLOTS];
  int          used_mirror;
  out_item_t   owed_results [$];
  int          errs;
  int          results_seen;

  task automatic owe_result(input out_item_t res);
    owed_results.insert(owed_results.size(), res);
  endtask

  task automatic mirror_insert(input in_item_t req);
    out_item_t res;
    int        pos;
    int        i;
    res = '0;
    res.last = 1'b1;
    if (used_mirror >= SLOTS) begin
      res.status = ST_FULL;
    end else begin
      if (used_mirror == 0 || int'(req.insertion_offset) >= used_mirror ||
          (slots_mirror[used_mirror-1].kind &&
           $signed(slots_mirror[used_mirror-1].prio) >= $signed(req.priority_req))) begin
        pos = used_mirror;
      end else begin
        pos = int'(req.insertion_offset);
        // walk past tombstones and entries ranking at or above the new one
        while (pos < used_mirror && (!slots_mirror[pos].kind ||
               $signed(slots_mirror[pos].prio) >= $signed(req.priority_req)))
          pos++;
        for (i = used_mirror; i > pos; i--)
          slots_mirror[i] = slots_mirror[i-1];
      end
      slots_mirror[pos] = '{tag: req.event_tag, prio: req.priority_req,
                            rcv: req.receiver, typ: req.event_type, kind: 1'b1};
      used_mirror++;
      res.status = ST_INSERTED;
    end
    owe_result(res);
  endtask

  task automatic mirror_take(input in_item_t req);
    out_item_t res;
    int        rd;
    int        wr;
    int        taken;
    logic      hit;
    wr = 0;
    taken = 0;
    for (rd = 0; rd < used_mirror; rd++) begin
      hit = slots_mirror[rd].kind && slots_mirror[rd].rcv == req.receiver &&
            (req.match_any_type || slots_mirror[rd].typ == req.event_type);
      if (hit) begin
        res = '0;
        res.status = ST_TAKEN;
        res.out_tag = slots_mirror[rd].tag;
        res.out_priority = slots_mirror[rd].prio;
        res.out_type = slots_mirror[rd].typ;
        owe_result(res);
        taken++;
        if (req.keep_slots) begin
          slots_mirror[rd].kind = 1'b0;
          slots_mirror[wr] = slots_mirror[rd];
          wr++;
        end
      end else begin
        // tombstones survive a compacting take
        slots_mirror[wr] = slots_mirror[rd];
        wr++;
      end
    end
    used_mirror = wr;
    if (taken == 0) begin
      res = '0;
      res.status = ST_NONE;
      res.last = 1'b1;
      owe_result(res);
    end else begin
      owed_results[owed_results.size()-1].last = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      used_mirror = 0;
      owed_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("result %0d unexpected: status %0d tag %h prio %0d type %h last %b",
                     results_seen, out_data.status, out_data.out_tag,
                     out_data.out_priority, out_data.out_type, out_data.last);
        end else begin
          want = owed_results.pop_front();
          if (out_data.status !== want.status || out_data.out_tag !== want.out_tag ||
              out_data.out_priority !== want.out_priority ||
              out_data.out_type !== want.out_type || out_data.last !== want.last) begin
            errs++;
            if (errs <= 10) begin
              $display("result %0d wrong: expected status %0d tag %h prio %0d type %h last %b",
                       results_seen, want.status, want.out_tag, want.out_priority,
                       want.out_type, want.last);
              $display("result %0d wrong: got      status %0d tag %h prio %0d type %h last %b",
                       results_seen, out_data.status, out_data.out_tag,
                       out_data.out_priority, out_data.out_type, out_data.last);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.op == OP_INSERT)
          mirror_insert(in_data);
        else
          mirror_take(in_data);
      end
    end
    mismatch_count <= errs;
    results_owed <= owed_results.size();
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stable priority event queue unit
// Directed inserts and takes around ordering, tombstones and empty takes,
// then random fill and drain bursts that reach a full table, under random
// sender gaps and receiver stalls. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import spq_pkg::*;

  localparam int SLOTS        = 32;
  localparam int ITEM_TOTAL   = 310;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 80;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        mismatch_count;
  int        results_owed;
  int        stall_pct;
  int        send_gap_pct;
  int        sent_n;
  int        quiet_cycles;

  stable_priority_event_queue_unit #(.SLOTS(SLOTS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  spq_result_checker #(.SLOTS(SLOTS)) results_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("stable_priority_event_queue_unit: mismatch");
      $finish;
    end
  end

  task automatic send_item(input in_item_t req);
    if (sent_n == ITEM_TOTAL / 3) begin
      send_gap_pct = 52;
      stall_pct <= 30;
    end else if (sent_n == 2 * ITEM_TOTAL / 3) begin
      send_gap_pct = 0;
      stall_pct <= 0;
    end
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    sent_n++;
  endtask

  task automatic send_insert(input logic [15:0] tag, input logic signed [15:0] prio,
                             input logic [15:0] rcv, input logic [15:0] typ,
                             input logic [5:0] off);
    in_item_t req;
    req.op = OP_INSERT;
    req.event_tag = tag;
    req.priority_req = prio;
    req.receiver = rcv;
    req.event_type = typ;
    req.match_any_type = 1'($urandom_range(1));
    req.keep_slots = 1'($urandom_range(1));
    req.insertion_offset = off;
    send_item(req);
  endtask

  task automatic send_take(input logic [15:0] rcv, input logic [15:0] typ,
                           input logic any_type, input logic keep);
    in_item_t req;
    req.op = OP_TAKE;
    req.event_tag = 16'($urandom);
    req.priority_req = 16'($urandom);
    req.receiver = rcv;
    req.event_type = typ;
    req.match_any_type = any_type;
    req.keep_slots = keep;
    req.insertion_offset = 6'($urandom_range(32));
    send_item(req);
  endtask

  function automatic logic signed [15:0] pick_priority();
    int r;
    r = $urandom_range(99);
    if (r < 40)
      return 16'(int'($urandom_range(4)) - 2);
    else if (r < 55)
      return r[0] ? 16'sh7FFF : 16'sh8000;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_receiver();
    int r;
    r = $urandom_range(99);
    if (r < 88)
      return 16'($urandom_range(3));
    else if (r < 94)
      return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_type();
    int r;
    r = $urandom_range(99);
    if (r < 85)
      return 16'($urandom_range(1));
    else if (r < 92)
      return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic [5:0] pick_offset();
    int r;
    r = $urandom_range(99);
    if (r < 50)
      return 6'd0;
    else if (r < 85)
      return 6'($urandom_range(8));
    return 6'($urandom_range(32));
  endfunction

  initial begin
    int  seg_len;
    int  fill_pct;
    int  j;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b0;
    stall_pct <= 52;
    send_gap_pct = 30;
    sent_n = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // take from an empty table
    send_take(16'd1, 16'd0, 1'b1, 1'b0);
    // empty append, then append behind a live slot of higher priority
    send_insert(16'h0001, 16'sd0, 16'd1, 16'd1, 6'd0);
    send_insert(16'h0002, 16'sh8000, 16'd1, 16'd2, 6'd0);
    // scan to the head, then an equal priority lands behind its peer
    send_insert(16'h0003, 16'sh7FFF, 16'd2, 16'd1, 6'd0);
    send_insert(16'h0004, 16'sd0, 16'd2, 16'd2, 6'd0);
    // offset past the used size appends out of order
    send_insert(16'h0005, 16'sd100, 16'd1, 16'd1, 6'd32);
    send_insert(16'h0006, 16'sd50, 16'd3, 16'd1, 6'd1);
    send_insert(16'hFFFF, 16'shFFFF, 16'hFFFF, 16'hFFFF, 6'd5);
    // leave a tombstone, then scan across it
    send_take(16'd1, 16'd2, 1'b0, 1'b1);
    send_insert(16'h0008, 16'sh8000, 16'd0, 16'd0, 6'd0);
    send_insert(16'h0009, -16'sd2, 16'd0, 16'd1, 6'd3);
    send_take(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    send_take(16'd1, 16'd0, 1'b1, 1'b0);
    send_take(16'd1, 16'd0, 1'b1, 1'b0);
    send_insert(16'h000A, 16'sd7, 16'd2, 16'd0, 6'd0);
    send_insert(16'h000B, 16'sd7, 16'd2, 16'd0, 6'd0);
    send_take(16'd2, 16'd0, 1'b0, 1'b1);
    send_take(16'd2, 16'd0, 1'b1, 1'b1);
    send_insert(16'hA5A5, 16'sh5A5A, 16'h5A5A, 16'hA5A5, 6'd31);
    send_take(16'h5A5A, 16'h0000, 1'b0, 1'b0);
    send_take(16'h5A5A, 16'hA5A5, 1'b0, 1'b0);
    send_take(16'd0, 16'd1, 1'b1, 1'b0);

    // one long fill so the table overflows early
    for (j = 0; j < 34; j++)
      send_insert(16'($urandom), pick_priority(), pick_receiver(), pick_type(),
                  pick_offset());

    // fill and drain bursts, each picked at random
    while (sent_n < ITEM_TOTAL) begin
      seg_len = $urandom_range(8, 40);
      fill_pct = $urandom_range(1) ? 85 : 35;
      for (j = 0; j < seg_len && sent_n < ITEM_TOTAL; j++) begin
        if ($urandom_range(99) < fill_pct)
          send_insert(16'($urandom), pick_priority(), pick_receiver(), pick_type(),
                      pick_offset());
        else
          send_take(pick_receiver(), pick_type(), 1'($urandom_range(1)),
                    $urandom_range(99) < 5);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0)
      $display("stable_priority_event_queue_unit: match");
    else
      $display("stable_priority_event_queue_unit: mismatch");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/spq_pkg.sv
hw/rtl/spq_cmp.sv
hw/rtl/stable_priority_event_queue_unit.sv
tb/sv/spq_result_checker.sv
tb/sv/testbench.sv
